// ----- hw/rtl/mte_pkg.sv -----
// Shared types, symbol codes and the Morse code table of the text encoder.
package mte_pkg;

   localparam int CharW   = 8;
   localparam int SymW    = 3;
   localparam int MaxSyms = 7;
   localparam int MaxCode = 6;
   localparam int CountW  = 3;
   localparam int LenW    = 3;

   // Symbol codes carried in the low bits of the result data.
   localparam logic [SymW-1:0] SYM_DOT     = 3'd0;
   localparam logic [SymW-1:0] SYM_DASH    = 3'd1;
   localparam logic [SymW-1:0] SYM_SLASH   = 3'd2;
   localparam logic [SymW-1:0] SYM_NEWLINE = 3'd3;
   localparam logic [SymW-1:0] SYM_GAP     = 3'd4;
   localparam logic [SymW-1:0] SYM_NONE    = 3'd5;

   localparam logic [CharW-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CharW-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CharW-1:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [CharW-1:0] CHAR_SPACE   = 8'h20;

   // One table entry: the code is left aligned, a set bit is a dash.
   typedef struct packed {
      logic               found;
      logic [LenW-1:0]    len;
      logic [MaxCode-1:0] pat;
   } code_type;

   // Everything the sequencer needs to play one character.
   typedef struct packed {
      logic                          is_valid;
      logic                          is_separator;
      logic                          is_newline;
      logic [CountW-1:0]             count;
      logic [MaxSyms-1:0][SymW-1:0]  syms;
   } lookup_type;

   function automatic code_type code_entry(input logic [CharW-1:0] c);
      code_type e;
      e = '{found: 1'b1, len: 3'd0, pat: 6'b000000};
      case (c)
         "a": begin e.len = 3'd2; e.pat = 6'b010000; end
         "b": begin e.len = 3'd4; e.pat = 6'b100000; end
         "c": begin e.len = 3'd4; e.pat = 6'b101000; end
         "d": begin e.len = 3'd3; e.pat = 6'b100000; end
         "e": begin e.len = 3'd1; e.pat = 6'b000000; end
         "f": begin e.len = 3'd4; e.pat = 6'b001000; end
         "g": begin e.len = 3'd3; e.pat = 6'b110000; end
         "h": begin e.len = 3'd4; e.pat = 6'b000000; end
         "i": begin e.len = 3'd2; e.pat = 6'b000000; end
         "j": begin e.len = 3'd4; e.pat = 6'b011100; end
         "k": begin e.len = 3'd3; e.pat = 6'b101000; end
         "l": begin e.len = 3'd4; e.pat = 6'b010000; end
         "m": begin e.len = 3'd2; e.pat = 6'b110000; end
         "n": begin e.len = 3'd2; e.pat = 6'b100000; end
         "o": begin e.len = 3'd3; e.pat = 6'b111000; end
         "p": begin e.len = 3'd4; e.pat = 6'b011000; end
         "q": begin e.len = 3'd4; e.pat = 6'b110100; end
         "r": begin e.len = 3'd3; e.pat = 6'b010000; end
         "s": begin e.len = 3'd3; e.pat = 6'b000000; end
         "t": begin e.len = 3'd1; e.pat = 6'b100000; end
         "u": begin e.len = 3'd3; e.pat = 6'b001000; end
         "v": begin e.len = 3'd4; e.pat = 6'b000100; end
         "w": begin e.len = 3'd3; e.pat = 6'b011000; end
         "x": begin e.len = 3'd4; e.pat = 6'b100100; end
         "y": begin e.len = 3'd4; e.pat = 6'b101100; end
         "z": begin e.len = 3'd4; e.pat = 6'b110000; end
         "1": begin e.len = 3'd5; e.pat = 6'b011110; end
         "2": begin e.len = 3'd5; e.pat = 6'b001110; end
         "3": begin e.len = 3'd5; e.pat = 6'b000110; end
         "4": begin e.len = 3'd5; e.pat = 6'b000010; end
         "5": begin e.len = 3'd5; e.pat = 6'b000000; end
         "6": begin e.len = 3'd5; e.pat = 6'b100000; end
         "7": begin e.len = 3'd5; e.pat = 6'b110000; end
         "8": begin e.len = 3'd5; e.pat = 6'b111000; end
         "9": begin e.len = 3'd5; e.pat = 6'b111100; end
         "0": begin e.len = 3'd5; e.pat = 6'b111110; end
         ".": begin e.len = 3'd6; e.pat = 6'b010101; end
         ",": begin e.len = 3'd6; e.pat = 6'b110011; end
         ":": begin e.len = 3'd6; e.pat = 6'b111000; end
         "?": begin e.len = 3'd6; e.pat = 6'b001100; end
         "'": begin e.len = 3'd6; e.pat = 6'b011110; end
         "-": begin e.len = 3'd6; e.pat = 6'b100001; end
         "/": begin e.len = 3'd5; e.pat = 6'b100100; end
         "(": begin e.len = 3'd5; e.pat = 6'b101100; end
         ")": begin e.len = 3'd6; e.pat = 6'b101101; end
         "\"": begin e.len = 3'd6; e.pat = 6'b010010; end
         "=": begin e.len = 3'd5; e.pat = 6'b100010; end
         "+": begin e.len = 3'd5; e.pat = 6'b010100; end
         "@": begin e.len = 3'd6; e.pat = 6'b011010; end
         default: begin
            e.found = 1'b0;
         end
      endcase
      return e;
   endfunction

endpackage

// ----- hw/rtl/mte_lookup.sv -----
// Character classifier: folds case and expands a byte into its symbol list.
module mte_lookup (
   input  logic [mte_pkg::CharW-1:0] character,
   output mte_pkg::lookup_type       info
);

   logic [mte_pkg::CharW-1:0] folded;
   mte_pkg::code_type         code;

   always_comb begin
      if (character >= "A" && character <= "Z") begin
         folded = character + 8'h20;
      end else begin
         folded = character;
      end
   end

   assign code = mte_pkg::code_entry(folded);

   always_comb begin
      info.is_valid     = 1'b1;
      info.is_separator = 1'b0;
      info.is_newline   = 1'b0;
      info.count        = 3'd1;
      info.syms         = {mte_pkg::MaxSyms{mte_pkg::SYM_GAP}};

      if (folded == mte_pkg::CHAR_NUL) begin
         info.is_separator = 1'b1;
      end else if (folded == mte_pkg::CHAR_SPACE) begin
         info.is_separator = 1'b1;
         info.count        = 3'd2;
         info.syms[0]      = mte_pkg::SYM_SLASH;
      end else if (folded == mte_pkg::CHAR_NEWLINE) begin
         info.is_separator = 1'b1;
         info.is_newline   = 1'b1;
         info.count        = 3'd2;
         info.syms[0]      = mte_pkg::SYM_NEWLINE;
      end else if (folded == mte_pkg::CHAR_TAB || !code.found) begin
         // A tab still ends the word; the separator flag handles that.
         info.is_valid     = 1'b0;
         info.is_separator = (folded == mte_pkg::CHAR_TAB);
         info.syms[0]      = mte_pkg::SYM_NONE;
      end else begin
         info.count = code.len + 3'd1;
         for (int k = 0; k < mte_pkg::MaxCode; k++) begin
            if (k < int'(code.len)) begin
               info.syms[k] = code.pat[mte_pkg::MaxCode-1-k] ?
                              mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
            end
         end
      end
   end

endmodule

// ----- hw/rtl/morse_text_encoder.sv -----
// Morse text encoder top level: input register, symbol sequencer and running counters.
//
//   channel | direction | tdata                                  | tuser   | tlast
//   --------+-----------+----------------------------------------+---------+---------------
//   req     | in        | character[7:0]                         | -       | -
//   rsp     | out       | symbol, line_number, converted_total,  | invalid | last symbol
//           |           | invalid_total, word_total, bad_word_t. |         | of character
//
// A request is taken into an input register, then expanded and played out one
// symbol per cycle while rsp is ready: its code followed by the closing gap. The
// input register takes the next request while the current character is still
// being played, so the port runs at full rate on results. From the input
// register a request is loaded into the sequencer once the sequencer is free,
// and its first symbol is then on the port.
// Reset is synchronous and clears the line count to one and all totals to zero.
// A stall on rsp holds the current symbol; req backs up after one held request.
module morse_text_encoder #(
   parameter int COUNTER_BITS = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // [7:0] character
   input  logic [mte_pkg::CharW-1:0]                req_tdata,

   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [2:0] symbol, then line_number, converted_total, invalid_total,
   // word_total, bad_word_total, each COUNTER_BITS wide, zero padded to bytes
   output logic [((3 + 5 * COUNTER_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // [0] invalid
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int CntW  = COUNTER_BITS;
   localparam int DataW = ((3 + 5 * COUNTER_BITS + 7) / 8) * 8;

   // Saturating increment shared by all counters.
   function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
      return (&v) ? v : v + CntW'(1);
   endfunction

   // Input register.
   logic                         hold_valid_ff, hold_valid_in;
   logic [mte_pkg::CharW-1:0]    hold_char_ff, hold_char_in;

   // Symbol sequencer; the head of the shift register is the symbol on the port.
   logic                                            out_valid_ff, out_valid_in;
   logic [mte_pkg::MaxSyms-1:0][mte_pkg::SymW-1:0]  syms_ff, syms_in;
   logic [mte_pkg::CountW-1:0]                      remain_ff, remain_in;
   logic                                            invalid_ff, invalid_in;
   logic [CntW-1:0]                                 line_here_ff, line_here_in;

   // Running totals; they already include the character being played.
   logic [CntW-1:0] line_count_ff, line_count_in;
   logic [CntW-1:0] converted_ff, converted_in;
   logic [CntW-1:0] invalid_cnt_ff, invalid_cnt_in;
   logic [CntW-1:0] word_ff, word_in;
   logic [CntW-1:0] bad_word_ff, bad_word_in;
   logic            word_err_ff, word_err_in;

   mte_pkg::lookup_type info;
   logic                req_take;
   logic                rsp_take;
   logic                seq_free;
   logic                load;
   logic                err_next;

   mte_lookup u_lookup (
      .character (hold_char_ff),
      .info      (info)
   );

   assign rsp_take = rsp_tvalid && rsp_tready;
   // The sequencer can take a new character when empty or once its final symbol leaves.
   assign seq_free = !out_valid_ff || (rsp_take && remain_ff == 3'd1);
   assign load     = hold_valid_ff && seq_free;
   assign req_tready = !hold_valid_ff || load;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_char_in  = hold_char_ff;
      if (req_take) begin
         hold_valid_in = 1'b1;
         hold_char_in  = req_tdata;
      end else if (load) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      syms_in        = syms_ff;
      remain_in      = remain_ff;
      invalid_in     = invalid_ff;
      line_here_in   = line_here_ff;
      line_count_in  = line_count_ff;
      converted_in   = converted_ff;
      invalid_cnt_in = invalid_cnt_ff;
      word_in        = word_ff;
      bad_word_in    = bad_word_ff;
      word_err_in    = word_err_ff;
      err_next       = word_err_ff || !info.is_valid;

      if (load) begin
         out_valid_in = 1'b1;
         syms_in      = info.syms;
         remain_in    = info.count;
         invalid_in   = !info.is_valid;
         // A newline reports the line it ends.
         line_here_in = line_count_ff;

         if (info.is_valid && !info.is_separator) begin
            converted_in = sat_inc(converted_ff);
         end
         if (!info.is_valid) begin
            invalid_cnt_in = sat_inc(invalid_cnt_ff);
         end
         if (info.is_separator) begin
            word_in     = sat_inc(word_ff);
            word_err_in = 1'b0;
            if (err_next) begin
               bad_word_in = sat_inc(bad_word_ff);
            end
            if (info.is_newline) begin
               line_count_in = sat_inc(line_count_ff);
            end
         end else begin
            word_err_in = err_next;
         end
      end else if (rsp_take) begin
         syms_in   = {mte_pkg::SYM_GAP, syms_ff[mte_pkg::MaxSyms-1:1]};
         remain_in = remain_ff - 3'd1;
         if (remain_ff == 3'd1) begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
         line_count_ff  <= CntW'(1);
         converted_ff   <= '0;
         invalid_cnt_ff <= '0;
         word_ff        <= '0;
         bad_word_ff    <= '0;
         word_err_ff    <= 1'b0;
         remain_ff      <= '0;
      end else begin
         hold_valid_ff  <= hold_valid_in;
         out_valid_ff   <= out_valid_in;
         line_count_ff  <= line_count_in;
         converted_ff   <= converted_in;
         invalid_cnt_ff <= invalid_cnt_in;
         word_ff        <= word_in;
         bad_word_ff    <= bad_word_in;
         word_err_ff    <= word_err_in;
         remain_ff      <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_char_ff <= hold_char_in;
      syms_ff      <= syms_in;
      invalid_ff   <= invalid_in;
      line_here_ff <= line_here_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = (remain_ff == 3'd1);
   assign rsp_tuser  = invalid_ff;
   assign rsp_tdata  = DataW'({bad_word_ff, word_ff, invalid_cnt_ff, converted_ff,
                               line_here_ff, syms_ff[0]});

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the Morse text encoder: directed and random text.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CntW = 24;
   localparam int RspW = ((3 + 5 * CntW + 7) / 8) * 8;
   localparam int PadLo = mte_pkg::SymW + 5 * CntW;
   localparam logic [CntW-1:0] CntMax = '1;
   // A healthy run never goes this long without a request or a result moving.
   localparam int IdleLimit = 4000;
   localparam int TailCycles = 20;
   localparam int RandomPerPhase = 21;

   // One result as the encoder should present it.
   typedef struct packed {
      logic [mte_pkg::SymW-1:0] symbol;
      logic                     last;
      logic                     invalid;
      logic [CntW-1:0]          line_no;
      logic [CntW-1:0]          converted;
      logic [CntW-1:0]          rejected;
      logic [CntW-1:0]          words;
      logic [CntW-1:0]          bad_words;
   } morse_result_type;

   // A directed row. The marks string, where given, spells the expected symbols:
   // '.' dot, '-' dash, '/' slash, 'n' newline, 'g' gap, 'x' none (invalid).
   typedef struct {
      logic [mte_pkg::CharW-1:0] ch;
      string                     marks;
   } text_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [mte_pkg::CharW-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RspW-1:0]           rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;

   // Marks that go with the request currently on the bus, empty for predicted rows.
   string               req_marks = "";

   // Encoder state as the testbench tracks it.
   logic [CntW-1:0]     cur_line = CntW'(1);
   logic [CntW-1:0]     n_converted = '0;
   logic [CntW-1:0]     n_rejected = '0;
   logic [CntW-1:0]     n_words = '0;
   logic [CntW-1:0]     n_bad_words = '0;
   logic                word_tainted = 1'b0;

   morse_result_type    pending_symbols[$];
   int                  errors = 0;
   int                  idle_cycles = 0;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;

   int                  phase_send[4] = '{0, 66, 0, 25};
   int                  phase_recv[4] = '{0, 0, 66, 25};

   // Directed text: the first character right after reset, the longest codes,
   // every symbol kind, separators, tab, bytes with the top bit set and bytes
   // that sit just outside the letter ranges.
   text_row_type directed_text[25] = '{
      '{"E", ".g"},            // upper case folded, first request after reset
      '{"c", "-.-.g"},
      '{"a", ".-g"},
      '{"Z", "--..g"},
      '{"0", "-----g"},
      '{".", ".-.-.-g"},       // six symbols plus the gap, the longest output
      '{"@", ".--.-.g"},
      '{mte_pkg::CHAR_SPACE, "/g"},
      '{mte_pkg::CHAR_NUL, "g"},        // word end with the gap alone
      '{8'hff, "x"},
      '{"#", "x"},
      '{mte_pkg::CHAR_SPACE, "/g"},     // closes a word that held an invalid byte
      '{mte_pkg::CHAR_TAB, "x"},
      '{mte_pkg::CHAR_TAB, "x"},        // a tab right after a tab ends an empty word
      '{"q", ""},
      '{mte_pkg::CHAR_NEWLINE, "ng"},
      '{8'h80, "x"},
      '{8'h5b, "x"},           // just above 'Z'
      '{8'h60, "x"},           // just below 'a'
      '{8'h7b, "x"},           // just above 'z'
      '{mte_pkg::CHAR_NEWLINE, "ng"},
      '{"\"", ""},
      '{"'", ""},
      '{"9", ""},
      '{"y", ""}
   };

   morse_text_encoder #(
      .COUNTER_BITS(CntW)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Counters stop at their top value instead of wrapping.
   function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
      return (v == CntMax) ? v : v + 1'b1;
   endfunction

   // International Morse code of a lower-case character, empty when there is none.
   function automatic string morse_code(input logic [mte_pkg::CharW-1:0] c);
      case (c)
         "a": return ".-";      "b": return "-...";    "c": return "-.-.";
         "d": return "-..";     "e": return ".";       "f": return "..-.";
         "g": return "--.";     "h": return "....";    "i": return "..";
         "j": return ".---";    "k": return "-.-";     "l": return ".-..";
         "m": return "--";      "n": return "-.";      "o": return "---";
         "p": return ".--.";    "q": return "--.-";    "r": return ".-.";
         "s": return "...";     "t": return "-";       "u": return "..-";
         "v": return "...-";    "w": return ".--";     "x": return "-..-";
         "y": return "-.--";    "z": return "--..";
         "1": return ".----";   "2": return "..---";   "3": return "...--";
         "4": return "....-";   "5": return ".....";   "6": return "-....";
         "7": return "--...";   "8": return "---..";   "9": return "----.";
         "0": return "-----";
         ".": return ".-.-.-";  ",": return "--..--";  ":": return "---...";
         "?": return "..--..";  "'": return ".----.";  "-": return "-....-";
         "/": return "-..-.";   "(": return "-.--.";   ")": return "-.--.-";
         "\"": return ".-..-."; "=": return "-...-";   "+": return ".-.-.";
         "@": return ".--.-.";
         default: return "";
      endcase
   endfunction

   // Works out every result one character causes and queues them. The running
   // totals already include the character; the line number is the one in
   // force before a newline advances it. Typed marks, where present, replace
   // the predicted symbols and the invalid flag.
   function automatic void encode_char(input logic [mte_pkg::CharW-1:0] raw,
                                       input string marks);
      logic [mte_pkg::CharW-1:0] c;
      string                     code;
      logic [mte_pkg::SymW-1:0]  syms[$];
      logic                      known;
      logic                      separator;
      logic [CntW-1:0]           line_here;
      morse_result_type          r;
      int                        i;

      c = raw;
      if (c >= "A" && c <= "Z") begin
         c = c + 8'd32;
      end
      line_here = cur_line;
      known = 1'b1;
      separator = 1'b0;

      if (c == mte_pkg::CHAR_NUL) begin
         separator = 1'b1;
      end else if (c == mte_pkg::CHAR_SPACE) begin
         syms.push_back(mte_pkg::SYM_SLASH);
         separator = 1'b1;
      end else if (c == mte_pkg::CHAR_NEWLINE) begin
         syms.push_back(mte_pkg::SYM_NEWLINE);
         separator = 1'b1;
      end else if (c == mte_pkg::CHAR_TAB) begin
         // A tab has no code but still ends the word.
         known = 1'b0;
         separator = 1'b1;
      end else begin
         code = morse_code(c);
         known = (code.len() != 0);
         for (i = 0; i < code.len(); i++) begin
            syms.push_back((code[i] == "-") ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT);
         end
      end

      if (known) begin
         syms.push_back(mte_pkg::SYM_GAP);
         if (!separator) begin
            n_converted = bump(n_converted);
         end
      end else begin
         syms.push_back(mte_pkg::SYM_NONE);
         n_rejected = bump(n_rejected);
         word_tainted = 1'b1;
      end

      if (separator) begin
         n_words = bump(n_words);
         if (word_tainted) begin
            n_bad_words = bump(n_bad_words);
         end
         word_tainted = 1'b0;
         if (c == mte_pkg::CHAR_NEWLINE) begin
            cur_line = bump(cur_line);
         end
      end

      if (marks.len() != 0) begin
         syms.delete();
         known = 1'b1;
         for (i = 0; i < marks.len(); i++) begin
            case (marks[i])
               ".": syms.push_back(mte_pkg::SYM_DOT);
               "-": syms.push_back(mte_pkg::SYM_DASH);
               "/": syms.push_back(mte_pkg::SYM_SLASH);
               "n": syms.push_back(mte_pkg::SYM_NEWLINE);
               "g": syms.push_back(mte_pkg::SYM_GAP);
               default: begin
                  syms.push_back(mte_pkg::SYM_NONE);
                  known = 1'b0;
               end
            endcase
         end
      end

      for (i = 0; i < syms.size(); i++) begin
         r.symbol    = syms[i];
         r.last      = (i == syms.size() - 1);
         r.invalid   = !known;
         r.line_no   = line_here;
         r.converted = n_converted;
         r.rejected  = n_rejected;
         r.words     = n_words;
         r.bad_words = n_bad_words;
         pending_symbols.push_back(r);
      end
   endfunction

   // Compares one field and reports it; returns the number of failures.
   function automatic int field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Prediction, checking and the watchdog share one process, so that a request
   // is always predicted before any result at the same edge is checked.
   always @(posedge clock) begin
      morse_result_type want;
      logic             moved;

      moved = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         encode_char(req_tdata, req_marks);
         moved = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         moved = 1'b1;
         if (pending_symbols.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual tdata 0x%h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_symbols.pop_front();
            errors += field_diff("symbol", 32'(want.symbol),
                                 32'(rsp_tdata[mte_pkg::SymW-1:0]));
            errors += field_diff("last", 32'(want.last), 32'(rsp_tlast));
            errors += field_diff("invalid", 32'(want.invalid), 32'(rsp_tuser));
            errors += field_diff("line_number", 32'(want.line_no),
                                 32'(rsp_tdata[mte_pkg::SymW +: CntW]));
            errors += field_diff("converted_total", 32'(want.converted),
                                 32'(rsp_tdata[mte_pkg::SymW + CntW +: CntW]));
            errors += field_diff("invalid_total", 32'(want.rejected),
                                 32'(rsp_tdata[mte_pkg::SymW + 2 * CntW +: CntW]));
            errors += field_diff("word_total", 32'(want.words),
                                 32'(rsp_tdata[mte_pkg::SymW + 3 * CntW +: CntW]));
            errors += field_diff("bad_word_total", 32'(want.bad_words),
                                 32'(rsp_tdata[mte_pkg::SymW + 4 * CntW +: CntW]));
            errors += field_diff("padding", '0, 32'(rsp_tdata[RspW-1:PadLo]));
         end
      end

      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("%0t: no request or result moved for %0d cycles", $time, IdleLimit);
         $display("morse_text_encoder regression: fail");
         $finish;
      end
   end

   // The receiver picks its ready for the coming edge at each falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Random text: mostly words of letters, digits and punctuation split by
   // spaces and newlines, with tabs, NUL and arbitrary bytes mixed in.
   function automatic logic [mte_pkg::CharW-1:0] pick_char();
      string punct;
      int    roll;

      punct = ".,:?'-/()\"=+@";
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return ($urandom_range(0, 3) == 0 ? "A" : "a") + 8'($urandom_range(0, 25));
      end else if (roll < 65) begin
         return "0" + 8'($urandom_range(0, 9));
      end else if (roll < 72) begin
         return punct[$urandom_range(0, punct.len() - 1)];
      end else if (roll < 82) begin
         return mte_pkg::CHAR_SPACE;
      end else if (roll < 87) begin
         return mte_pkg::CHAR_NEWLINE;
      end else if (roll < 90) begin
         return mte_pkg::CHAR_TAB;
      end else if (roll < 92) begin
         return mte_pkg::CHAR_NUL;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Entered just after a falling edge; returns at the falling edge after the
   // request is taken, with valid still high so the next request can follow
   // without a bubble.
   task automatic send_char(input logic [mte_pkg::CharW-1:0] ch, input string marks);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_marks   = marks;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Holds the sender off until every expected result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_symbols.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_text[i]) begin
         send_char(directed_text[i].ch, directed_text[i].marks);
      end
      drain();

      // Flow-control phases: none, a lazy sender, a stalling receiver, then both.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         for (int n = 0; n < RandomPerPhase; n++) begin
            send_char(pick_char(), "");
         end
         drain();
      end

      repeat (TailCycles) @(negedge clock);
      if (errors == 0 && pending_symbols.size() == 0) begin
         $display("morse_text_encoder regression: pass");
      end else begin
         $display("morse_text_encoder regression: fail");
      end
      $finish;
   end

endmodule
